[sv/dacap_pkg.sv]
// shared types and constants for the dac level assembler with pop suppression
`timescale 1ns / 1ps

package dacap_pkg;

    // request kinds carried on the input tuser
    localparam logic REQ_HIGH = 1'b0;
    localparam logic REQ_LOW  = 1'b1;

    // level and word constants
    localparam int          LEVEL_W    = 10;
    localparam int          WORD_W     = 16;
    localparam int          COUNTER_W  = 16;
    localparam int          STATUS_W   = 2;
    localparam logic [9:0]  MID_SCALE  = 10'h100;
    localparam logic [15:0] DAC_OFFSET = 16'h4000;
    localparam logic [1:0]  DDR_GATE   = 2'b11;

    // packed widths of the stream buses
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // one input request after unpacking
    typedef struct packed {
        logic                 req_type;
        logic [7:0]           port_data;
        logic [COUNTER_W-1:0] music_counter;
        logic [7:0]           ddr_b_bits;
    } req_t;

    // one result after processing
    typedef struct packed {
        logic                dac_strobe;
        logic [WORD_W-1:0]   dac_word;
        logic [STATUS_W-1:0] status_bits;
        logic                muted_flag;
    } result_t;

    // configuration write toward the core
    typedef struct packed {
        logic wr;
        logic value;
    } cfg_wr_t;

endpackage

[sv/dac_assembler_pop_suppressor.sv]
// top level: stream ports, input and result registers, config port
`timescale 1ns / 1ps

// channel   direction  signals                          contents
// s_axis    in         tvalid tready tdata tuser        port write request
// m_axis    out        tvalid tready tdata tuser        dac sample and status
// cfg       in         cfg_valid cfg_ready cfg_data     pop_suppress_enable
//
// a request accepted on s_axis waits in the input register and moves to the result register
// when that register is empty or being read; state updates as the request leaves the input
// register. one request per cycle is sustained while m_axis_tready stays high.
// aresetn is synchronous, active low; it clears the valid flags, all core state and the enable.
// a stall on m_axis holds the result register, then the input register, and
// only then drops s_axis_tready; cfg_ready is low while the input register is full.

module dac_assembler_pop_suppressor
    import dacap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input request
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] port_data, [23:8] music_counter, [31:24] ddr_b_bits
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  logic                 s_axis_tuser,
    // result
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] dac_word, [17:16] status_bits, [18] muted_flag, [23:19] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] dac_strobe
    output logic                 m_axis_tuser,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    logic    in_valid_reg;
    req_t    in_req_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;
    cfg_wr_t cfg_wr;

    // handshake control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = !in_valid_reg;
    assign cfg_wr.wr     = cfg_valid && cfg_ready;
    assign cfg_wr.value  = cfg_data;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg.req_type      <= s_axis_tuser;
            in_req_reg.port_data     <= s_axis_tdata[7:0];
            in_req_reg.music_counter <= s_axis_tdata[23:8];
            in_req_reg.ddr_b_bits    <= s_axis_tdata[31:24];
        end
    end

    dacap_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .advance (advance),
        .req     (in_req_reg),
        .result  (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.dac_strobe;
    assign m_axis_tdata  = {5'b0, out_res_reg.muted_flag, out_res_reg.status_bits,
                            out_res_reg.dac_word};

    // a silent result carries a zero word
    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0)
        else $error("silent result with nonzero dac word");

    // a request leaving the input register shows up as a result
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_axis_tvalid)
        else $error("processed request lost before result register");

    // a held request blocks new input
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> !s_axis_tready)
        else $error("input register overwritten while held");

endmodule

[sv/dacap_core.sv]
// state registers and single-pass update logic for one request
`timescale 1ns / 1ps

module dacap_core
    import dacap_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_wr_t cfg_wr,
    input  logic    advance,
    input  req_t    req,
    output result_t result
);

    logic                 enable_reg;
    logic [LEVEL_W-1:0]   level_reg,   level_next;
    logic [LEVEL_W-1:0]   saved_reg,   saved_next;
    logic [COUNTER_W-1:0] last_reg,    last_next;
    logic                 ending_reg,  ending_next;
    logic                 mute_reg,    mute_next;
    logic                 boot_reg,    boot_next;
    logic [STATUS_W-1:0]  status_reg,  status_next;

    logic [LEVEL_W-1:0] lvl_a;
    logic [LEVEL_W-1:0] lvl_b;
    logic               end_b;
    logic               stalled;

    // next state for the request held in the input register
    always_comb begin
        saved_next  = saved_reg;
        last_next   = last_reg;
        ending_next = ending_reg;
        mute_next   = mute_reg;
        boot_next   = boot_reg;
        status_next = status_reg;
        lvl_a       = level_reg;
        lvl_b       = level_reg;
        end_b       = ending_reg;
        stalled     = (last_reg == req.music_counter) || (req.music_counter == '0);
        level_next  = level_reg;

        unique case (req.req_type)
            REQ_HIGH: begin
                // upper bits take the byte unless muted
                if (!mute_reg) begin
                    saved_next = level_reg;
                    lvl_a      = {req.port_data, level_reg[1:0]};
                end
                level_next = lvl_a;
                if (enable_reg) begin
                    if (stalled) begin
                        // fall back to the level before this write
                        if (!mute_reg) begin
                            lvl_b = saved_next;
                            end_b = 1'b1;
                        end else begin
                            lvl_b = lvl_a;
                        end
                        ending_next = end_b;
                        // ramp one step toward mid-scale
                        if (lvl_b > MID_SCALE) begin
                            level_next = lvl_b - 1'b1;
                        end else if (lvl_b < MID_SCALE) begin
                            level_next = lvl_b + 1'b1;
                        end else begin
                            level_next = lvl_b;
                            if (end_b) begin
                                ending_next = 1'b0;
                                boot_next   = 1'b0;
                                saved_next  = MID_SCALE;
                            end
                        end
                        mute_next = 1'b1;
                    end else begin
                        mute_next = 1'b0;
                    end
                    last_next = req.music_counter;
                end
            end
            REQ_LOW: begin
                // lowest two bits from the top of the byte
                if (!mute_reg) begin
                    saved_next = level_reg;
                    level_next = {level_reg[LEVEL_W-1:2], req.port_data[7:6]};
                end
                if (req.ddr_b_bits[5:4] != DDR_GATE) begin
                    status_next = req.port_data[5:4];
                end
            end
            default: begin
                level_next = level_reg;
            end
        endcase
    end

    // result fields from the updated state
    always_comb begin
        result.dac_strobe  = !boot_next;
        result.dac_word    = boot_next ? '0
                           : WORD_W'(DAC_OFFSET + {level_next, 6'b0});
        result.status_bits = status_next;
        result.muted_flag  = mute_next;
    end

    // state update, config write loads enable and boot together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            level_reg  <= '0;
            saved_reg  <= '0;
            last_reg   <= '0;
            ending_reg <= 1'b0;
            mute_reg   <= 1'b0;
            boot_reg   <= 1'b0;
            status_reg <= '0;
        end else if (cfg_wr.wr) begin
            enable_reg <= cfg_wr.value;
            boot_reg   <= cfg_wr.value;
        end else if (advance) begin
            level_reg  <= level_next;
            saved_reg  <= saved_next;
            last_reg   <= last_next;
            ending_reg <= ending_next;
            mute_reg   <= mute_next;
            boot_reg   <= boot_next;
            status_reg <= status_next;
        end
    end

endmodule

[tb/tb_dac_assembler_pop_suppressor.sv]
// testbench for the dac level assembler with pop suppression: predicted results vs stream output
`timescale 1ns / 1ps

module tb_dac_assembler_pop_suppressor;
    import dacap_pkg::*;

    localparam int PIPE_LAT    = 2;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 200000;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #2 aclk = ~aclk;

    // block ports
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data      = 1'b0;

    dac_assembler_pop_suppressor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // predictor copy of the block state
    logic                 supp_en      = 1'b0;
    logic [LEVEL_W-1:0]   lvl          = '0;
    logic [LEVEL_W-1:0]   saved_lvl    = '0;
    logic [COUNTER_W-1:0] prev_counter = '0;
    logic                 ending       = 1'b0;
    logic                 muted        = 1'b0;
    logic                 booting      = 1'b0;
    logic [STATUS_W-1:0]  status       = '0;

    result_t pending_results[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trig     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    logic [COUNTER_W-1:0] music_ctr = 16'h0001;

    // next dac result after one port write, updates the predictor state
    function automatic result_t predict_dac_result(input req_t r);
        result_t res;
        if (r.req_type == REQ_HIGH) begin
            if (!muted) begin
                saved_lvl = lvl;
                lvl       = {r.port_data, lvl[1:0]};
            end
            if (supp_en) begin
                if (prev_counter == r.music_counter || r.music_counter == '0) begin
                    // counter stalled or zero: fall back and ramp toward mid-scale
                    if (!muted) begin
                        lvl    = saved_lvl;
                        ending = 1'b1;
                    end
                    if (lvl > MID_SCALE)
                        lvl = lvl - 1'b1;
                    else if (lvl < MID_SCALE)
                        lvl = lvl + 1'b1;
                    else if (ending) begin
                        ending    = 1'b0;
                        booting   = 1'b0;
                        saved_lvl = MID_SCALE;
                    end
                    muted = 1'b1;
                end else begin
                    muted = 1'b0;
                end
                prev_counter = r.music_counter;
            end
        end else begin
            if (!muted) begin
                saved_lvl = lvl;
                lvl       = {lvl[9:2], r.port_data[7:6]};
            end
            // status follows the data unless both direction bits are outputs
            if (r.ddr_b_bits[5:4] != DDR_GATE)
                status = r.port_data[5:4];
        end
        res.dac_strobe  = !booting;
        res.dac_word    = booting ? '0 : DAC_OFFSET + {lvl, 6'b0};
        res.status_bits = status;
        res.muted_flag  = muted;
        return res;
    endfunction

    // send one port write request, predict its result on acceptance
    task automatic send_req(input logic kind, input logic [7:0] data,
                            input logic [15:0] ctr, input logic [7:0] ddr);
        req_t r;
        r.req_type      = kind;
        r.port_data     = data;
        r.music_counter = ctr;
        r.ddr_b_bits    = ddr;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ddr, ctr, data};
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        pending_results.push_back(predict_dac_result(r));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // write the enable while idle; it also rearms boot silence
    task automatic write_enable(input logic v);
        drain_results();
        repeat (PIPE_LAT + 2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        supp_en = v;
        booting = v;
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle_pct = snd;
        recv_idle_pct <= rcv;
    endtask

    // high port byte, often near mid-scale so ramps end quickly
    function automatic logic [7:0] pick_level_byte();
        if ($urandom_range(0, 9) < 4)
            return 8'($urandom_range(8'h3c, 8'h44));
        return 8'($urandom_range(0, 255));
    endfunction

    // music sessions: counter advancing, then stalling, with some noise
    task automatic run_random(input int n_items);
        int sent;
        int plays;
        int stalls;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 2) begin
                send_req(1'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                sent++;
            end else begin
                plays = $urandom_range(1, 8);
                for (k = 0; k < plays; k++) begin
                    music_ctr = music_ctr + 16'($urandom_range(1, 600));
                    if (music_ctr == '0)
                        music_ctr = 16'h0001;
                    send_req(REQ_HIGH, pick_level_byte(), music_ctr, 8'($urandom));
                    sent++;
                    if ($urandom_range(0, 1)) begin
                        send_req(REQ_LOW, 8'($urandom), 16'($urandom), 8'($urandom));
                        sent++;
                    end
                end
                stalls = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6);
                for (k = 0; k < stalls; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_req(REQ_HIGH, 8'($urandom), 16'h0000, 8'($urandom));
                    else
                        send_req(REQ_HIGH, 8'($urandom), music_ctr, 8'($urandom));
                    sent++;
                    if ($urandom_range(0, 3) == 0) begin
                        send_req(REQ_LOW, 8'($urandom), 16'($urandom), 8'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    // compare one accepted result against the oldest prediction
    task automatic check_dac_result(input logic [M_TDATA_W-1:0] tdata, input logic tuser);
        result_t want;
        if (pending_results.size() == 0) begin
            $error("result with no request outstanding: tdata=%h tuser=%b", tdata, tuser);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (tuser !== want.dac_strobe) begin
                $error("dac_strobe: expected %b, got %b", want.dac_strobe, tuser);
                fail_count++;
            end
            if (tdata[15:0] !== want.dac_word) begin
                $error("dac_word: expected %h, got %h", want.dac_word, tdata[15:0]);
                fail_count++;
            end
            if (tdata[17:16] !== want.status_bits) begin
                $error("status_bits: expected %b, got %b", want.status_bits, tdata[17:16]);
                fail_count++;
            end
            if (tdata[18] !== want.muted_flag) begin
                $error("muted_flag: expected %b, got %b", want.muted_flag, tdata[18]);
                fail_count++;
            end
        end
    endtask

    // receiver: check results, random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            check_dac_result(m_axis_tdata, m_axis_tuser);
        if (hold_seen != hold_trig) begin
            hold_seen     <= hold_trig;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // suppression off: field extremes, status gate, word wrap
    task automatic test_directed_plain();
        send_req(REQ_HIGH, 8'h00, 16'h0000, 8'h00);
        send_req(REQ_HIGH, 8'hff, 16'hffff, 8'h00);
        send_req(REQ_LOW,  8'hff, 16'h0000, 8'h00);
        send_req(REQ_LOW,  8'h00, 16'hffff, 8'hff);
        send_req(REQ_LOW,  8'h20, 16'h0000, 8'h30);
        send_req(REQ_LOW,  8'h10, 16'h0000, 8'h20);
        send_req(REQ_LOW,  8'hc0, 16'h0000, 8'h10);
        send_req(REQ_HIGH, 8'h80, 16'h1234, 8'hff);
        send_req(REQ_HIGH, 8'h7f, 16'h1234, 8'hff);
        send_req(REQ_LOW,  8'h40, 16'h0000, 8'hef);
    endtask

    // suppression on: boot silence, stall and zero counter, ramp, mid-scale
    task automatic test_directed_suppress();
        write_enable(1'b1);
        send_req(REQ_HIGH, 8'h40, 16'h0001, 8'h00);
        send_req(REQ_LOW,  8'h00, 16'h0000, 8'h00);
        send_req(REQ_HIGH, 8'h40, 16'h0002, 8'h00);
        send_req(REQ_HIGH, 8'h40, 16'h0002, 8'h00);
        send_req(REQ_LOW,  8'hc0, 16'h0000, 8'h00);
        send_req(REQ_HIGH, 8'h00, 16'h0003, 8'h00);
        send_req(REQ_HIGH, 8'ha0, 16'h0004, 8'h00);
        send_req(REQ_HIGH, 8'h11, 16'h0000, 8'h00);
        send_req(REQ_HIGH, 8'h11, 16'h0000, 8'h00);
        send_req(REQ_HIGH, 8'h22, 16'h0000, 8'h00);
        send_req(REQ_LOW,  8'h3f, 16'h0000, 8'h30);
        send_req(REQ_HIGH, 8'h00, 16'h0005, 8'h00);
        send_req(REQ_HIGH, 8'h00, 16'h0006, 8'h00);
        send_req(REQ_HIGH, 8'h00, 16'h0006, 8'h00);
        music_ctr = 16'h0007;
    endtask

    task automatic test_random_slow_receiver();
        set_idling(10, 50);
        run_random(300);
    endtask

    task automatic test_random_slow_sender();
        set_idling(50, 10);
        write_enable(1'b0);
        run_random(150);
        write_enable(1'b1);
        run_random(150);
    endtask

    task automatic test_random_full_rate();
        set_idling(0, 0);
        write_enable(1'b1);
        run_random(270);
    endtask

    // receiver holds off long enough to fill the block, then sender pauses
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_trig <= hold_trig + 1;
        run_random(30);
        drain_results();
        run_random(20);
    endtask

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("dac_assembler_pop_suppressor verification failed");
        $finish;
    end

    // test sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_plain();
        test_directed_suppress();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();
        test_backpressure();
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("dac_assembler_pop_suppressor verification clean");
        else
            $display("dac_assembler_pop_suppressor verification failed");
        $finish;
    end

endmodule
